FILE: hw/rtl/wcf_pkg.sv
// ============================================================================
// wcf_pkg
// Shared types, constants and LED color logic for the word clock frame block.
// ============================================================================
package wcf_pkg;

  // Frame geometry
  localparam int unsigned FRAME_PAIRS = 62;
  localparam int unsigned PAIR_W      = 6;
  localparam int unsigned LED_W       = PAIR_W + 1;
  localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(FRAME_PAIRS - 1);

  // Color and configuration port widths
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_CLOCK       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_ACTIVE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BACKGROUND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_AMPM       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_SECOND     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MINUTE     = 3'd5;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // Minute word classes (minute / 5, saturated at eleven)
  localparam logic [3:0] MC_NONE        = 4'd0;
  localparam logic [3:0] MC_FIVE_PAST   = 4'd1;
  localparam logic [3:0] MC_TEN_PAST    = 4'd2;
  localparam logic [3:0] MC_QTR_PAST    = 4'd3;
  localparam logic [3:0] MC_TWENTY_PAST = 4'd4;
  localparam logic [3:0] MC_FIVE_TO_HALF = 4'd5;
  localparam logic [3:0] MC_HALF        = 4'd6;
  localparam logic [3:0] MC_FIVE_PAST_HALF = 4'd7;
  localparam logic [3:0] MC_TWENTY_TO   = 4'd8;
  localparam logic [3:0] MC_QTR_TO      = 4'd9;
  localparam logic [3:0] MC_TEN_TO      = 4'd10;
  localparam logic [3:0] MC_FIVE_TO     = 4'd11;

  // Classified time item, one per frame
  typedef struct packed {
    logic       show;
    logic       pm;
    logic [3:0] hword;     // 0..12, 0 and 12 both mean twelve
    logic       min_lt5;
    logic [3:0] mclass;
    logic [2:0] dots;      // minute mod 5
    logic [3:0] sec_led;   // second mod 10
  } desc_t;

  // Configured colors, already in GRB order
  typedef struct packed {
    logic               show;
    logic [COLOR_W-1:0] act;
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] ampm;
    logic [COLOR_W-1:0] sec;
    logic [COLOR_W-1:0] minc;
  } cfg_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [COLOR_W-1:0] to_grb(input logic [COLOR_W-1:0] rgb);
    return {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

  function automatic logic in_rng(input logic [LED_W-1:0] idx,
                                  input int unsigned lo, input int unsigned hi);
    return (idx >= LED_W'(lo)) && (idx <= LED_W'(hi));
  endfunction

  // Color of one LED, painted in the same order as the frame is built
  function automatic logic [COLOR_W-1:0] led_grb(input logic [LED_W-1:0] idx,
                                                 input desc_t d, input cfg_t c);
    logic [COLOR_W-1:0] col;
    logic               w_before;
    logic               w_after;
    col      = '0;
    w_before = 1'b0;
    w_after  = 1'b0;
    if (d.show) begin
      if (in_rng(idx, 0, 109)) col = c.bg;
      // AM / PM marker
      if (d.pm) begin
        if (in_rng(idx, 59, 60)) col = '0;
        if (in_rng(idx, 70, 71)) col = c.ampm;
      end else begin
        if (in_rng(idx, 70, 71)) col = '0;
        if (in_rng(idx, 59, 60)) col = c.ampm;
      end
      // hour word
      case (d.hword)
        4'd1: begin
          if (d.min_lt5) begin
            if (in_rng(idx, 63, 65)) col = c.act;
          end else begin
            if (in_rng(idx, 62, 65)) col = c.act;
          end
        end
        4'd2:  if (in_rng(idx, 55, 58)) col = c.act;
        4'd3:  if (in_rng(idx, 66, 69)) col = c.act;
        4'd4:  if (in_rng(idx, 73, 76)) col = c.act;
        4'd5:  if (in_rng(idx, 51, 54)) col = c.act;
        4'd6:  if (in_rng(idx, 83, 87)) col = c.act;
        4'd7:  if (in_rng(idx, 88, 93)) col = c.act;
        4'd8:  if (in_rng(idx, 77, 80)) col = c.act;
        4'd9:  if (in_rng(idx, 103, 106)) col = c.act;
        4'd10: if (in_rng(idx, 106, 109)) col = c.act;
        4'd11: if (in_rng(idx, 49, 51)) col = c.act;
        default: if (in_rng(idx, 94, 98)) col = c.act;
      endcase
      // minute words
      case (d.mclass)
        MC_FIVE_TO: begin
          if (in_rng(idx, 7, 10)) col = c.act;
          w_before = 1'b1;
        end
        MC_TEN_TO: begin
          if (in_rng(idx, 18, 21)) col = c.act;
          w_before = 1'b1;
        end
        MC_QTR_TO: begin
          if (in_rng(idx, 26, 32)) col = c.act;
          w_before = 1'b1;
        end
        MC_TWENTY_TO: begin
          if (in_rng(idx, 11, 17)) col = c.act;
          w_before = 1'b1;
        end
        MC_FIVE_PAST_HALF: begin
          if (in_rng(idx, 7, 10) || in_rng(idx, 44, 47)) col = c.act;
          w_after = 1'b1;
        end
        MC_HALF: begin
          if (in_rng(idx, 44, 47)) col = c.act;
        end
        MC_FIVE_TO_HALF: begin
          if (in_rng(idx, 7, 10) || in_rng(idx, 44, 47)) col = c.act;
          w_before = 1'b1;
        end
        MC_TWENTY_PAST: begin
          if (in_rng(idx, 11, 17)) col = c.act;
          w_after = 1'b1;
        end
        MC_QTR_PAST: begin
          if (in_rng(idx, 26, 32)) col = c.act;
          w_after = 1'b1;
        end
        MC_TEN_PAST: begin
          if (in_rng(idx, 18, 21)) col = c.act;
          w_after = 1'b1;
        end
        MC_FIVE_PAST: begin
          if (in_rng(idx, 7, 10)) col = c.act;
          w_after = 1'b1;
        end
        default: ;
      endcase
      // VOR blanks NACH and the other way round
      if (w_before) begin
        if (in_rng(idx, 33, 36)) col = '0;
        if (in_rng(idx, 41, 43)) col = c.act;
      end
      if (w_after) begin
        if (in_rng(idx, 41, 43)) col = '0;
        if (in_rng(idx, 33, 36)) col = c.act;
      end
      // minute dots
      case (d.dots)
        3'd0: if (in_rng(idx, 120, 123)) col = '0;
        3'd1: if (in_rng(idx, 122, 122)) col = c.minc;
        3'd2: if (in_rng(idx, 122, 123)) col = c.minc;
        3'd3: if (in_rng(idx, 122, 123) || in_rng(idx, 120, 120)) col = c.minc;
        default: if (in_rng(idx, 120, 123)) col = c.minc;
      endcase
      // seconds LED
      if (in_rng(idx, 110, 119)) col = '0;
      if (idx == LED_W'(7'd110 + 7'(d.sec_led))) col = c.sec;
      // ES IST, UHR
      if (in_rng(idx, 0, 1) || in_rng(idx, 3, 5)) col = c.act;
      if (d.min_lt5 && in_rng(idx, 99, 101)) col = c.act;
    end
    return col;
  endfunction

endpackage

FILE: hw/rtl/wcf_time_if.sv
// ============================================================================
// wcf_time_if
// Time item channel: hour, minute and second with valid/ready.
// ============================================================================
interface wcf_time_if;
  logic       valid;
  logic       ready;
  logic [4:0] hour_in;
  logic [5:0] minute_in;
  logic [5:0] second_in;

  modport source (output valid, hour_in, minute_in, second_in, input ready);
  modport sink   (input valid, hour_in, minute_in, second_in, output ready);
endinterface

FILE: hw/rtl/wcf_pair_if.sv
// ============================================================================
// wcf_pair_if
// Pixel pair channel: one beat per pair of LEDs, GRB colors.
// ============================================================================
interface wcf_pair_if;
  logic                            valid;
  logic                            ready;
  logic [wcf_pkg::PAIR_W-1:0]      pair_index;
  logic [wcf_pkg::COLOR_W-1:0]     even_pixel;
  logic [wcf_pkg::COLOR_W-1:0]     odd_pixel;
  logic                            last;

  modport source (output valid, pair_index, even_pixel, odd_pixel, last, input ready);
  modport sink   (input valid, pair_index, even_pixel, odd_pixel, last, output ready);
endinterface

FILE: hw/rtl/wcf_cfg_if.sv
// ============================================================================
// wcf_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ============================================================================
interface wcf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [wcf_pkg::CFG_IDX_W-1:0]     index;
  logic [wcf_pkg::COLOR_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/wcf_cfg_regs.sv
// ============================================================================
// wcf_cfg_regs
// Configuration register file; colors leave converted to GRB order.
// ============================================================================
module wcf_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  wcf_cfg_if.sink          cfg_wr,
  output wcf_pkg::cfg_t    cfg
);

  logic                            show_r;
  logic [wcf_pkg::COLOR_W-1:0]     act_r;
  logic [wcf_pkg::COLOR_W-1:0]     bg_r;
  logic [wcf_pkg::COLOR_W-1:0]     ampm_r;
  logic [wcf_pkg::COLOR_W-1:0]     sec_r;
  logic [wcf_pkg::COLOR_W-1:0]     minc_r;
  logic                            wr_en;

  // always take a write beat
  assign cfg_wr.ready = 1'b1;
  assign wr_en        = cfg_wr.valid;

  // decode the index and update one register, drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_r <= 1'b0;
      act_r  <= '0;
      bg_r   <= '0;
      ampm_r <= '0;
      sec_r  <= '0;
      minc_r <= '0;
    end else if (wr_en) begin
      case (cfg_wr.index)
        wcf_pkg::REG_SHOW_CLOCK:       show_r <= cfg_wr.data[0];
        wcf_pkg::REG_COLOR_ACTIVE:     act_r  <= cfg_wr.data;
        wcf_pkg::REG_COLOR_BACKGROUND: bg_r   <= cfg_wr.data;
        wcf_pkg::REG_COLOR_AMPM:       ampm_r <= cfg_wr.data;
        wcf_pkg::REG_COLOR_SECOND:     sec_r  <= cfg_wr.data;
        wcf_pkg::REG_COLOR_MINUTE:     minc_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // present colors in LED wire order
  always_comb begin
    cfg.show = show_r;
    cfg.act  = wcf_pkg::to_grb(act_r);
    cfg.bg   = wcf_pkg::to_grb(bg_r);
    cfg.ampm = wcf_pkg::to_grb(ampm_r);
    cfg.sec  = wcf_pkg::to_grb(sec_r);
    cfg.minc = wcf_pkg::to_grb(minc_r);
  end

endmodule

FILE: hw/rtl/wcf_front.sv
// ============================================================================
// wcf_front
// Accepts time items and classifies them into frame descriptors.
// ============================================================================
module wcf_front (
  input  logic             show_clock,
  wcf_time_if.sink         in_time,
  input  wcf_pkg::qstat_t  qstat,
  output logic             push,
  output wcf_pkg::desc_t   desc
);

  logic [3:0] min_q;      // minute / 5, 0..12
  logic [3:0] sec_q;      // second / 10, 0..6
  logic [5:0] min_rem;
  logic [5:0] sec_rem;
  logic [4:0] hour12;

  // take a beat whenever the queue has room
  assign in_time.ready = !qstat.full;
  assign push          = in_time.valid && !qstat.full;

  // quotients by comparison against multiples
  always_comb begin
    min_q = '0;
    for (int k = 1; k <= 12; k++) begin
      if (in_time.minute_in >= 6'(5 * k)) min_q = 4'(k);
    end
    sec_q = '0;
    for (int k = 1; k <= 6; k++) begin
      if (in_time.second_in >= 6'(10 * k)) sec_q = 4'(k);
    end
  end

  // remainders and hour folding
  always_comb begin
    min_rem = in_time.minute_in - (6'({min_q, 2'b00}) + 6'(min_q));
    sec_rem = in_time.second_in - (6'({sec_q, 3'b000}) + 6'({sec_q, 1'b0}));
    if (in_time.hour_in >= 5'd24)      hour12 = in_time.hour_in - 5'd24;
    else if (in_time.hour_in >= 5'd12) hour12 = in_time.hour_in - 5'd12;
    else                               hour12 = in_time.hour_in;
  end

  // build the descriptor
  always_comb begin
    desc.show    = show_clock;
    desc.pm      = in_time.hour_in >= 5'd12;
    desc.hword   = hour12[3:0] + 4'(in_time.minute_in >= 6'd25);
    desc.min_lt5 = in_time.minute_in < 6'd5;
    desc.mclass  = (min_q > wcf_pkg::MC_FIVE_TO) ? wcf_pkg::MC_FIVE_TO : min_q;
    desc.dots    = min_rem[2:0];
    desc.sec_led = sec_rem[3:0];
  end

endmodule

FILE: hw/rtl/wcf_queue.sv
// ============================================================================
// wcf_queue
// Short descriptor queue between the front and the back.
// ============================================================================
module wcf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wcf_pkg::desc_t   push_desc,
  input  logic             pop,
  output wcf_pkg::desc_t   head,
  output wcf_pkg::qstat_t  qstat
);

  wcf_pkg::desc_t                  mem_r [wcf_pkg::QUEUE_DEPTH];
  logic [wcf_pkg::QPTR_W-1:0]      wr_ptr_r;
  logic [wcf_pkg::QPTR_W-1:0]      rd_ptr_r;
  logic [wcf_pkg::QCNT_W-1:0]      count_r;
  logic [wcf_pkg::QCNT_W-1:0]      count_nxt;

  assign qstat.full  = count_r == wcf_pkg::QCNT_W'(wcf_pkg::QUEUE_DEPTH);
  assign qstat.empty = count_r == '0;
  assign head        = mem_r[rd_ptr_r];

  // track occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_desc;
  end

endmodule

FILE: hw/rtl/wcf_back.sv
// ============================================================================
// wcf_back
// Serializes the head descriptor into 62 pixel pair beats.
// ============================================================================
module wcf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  wcf_pkg::desc_t   head,
  input  wcf_pkg::qstat_t  qstat,
  input  wcf_pkg::cfg_t    cfg,
  output logic             pop,
  wcf_pair_if.source       out_pair
);

  logic [wcf_pkg::PAIR_W-1:0]   pair_r;
  logic [wcf_pkg::PAIR_W-1:0]   pair_nxt;
  logic                         out_valid_r;
  logic [wcf_pkg::PAIR_W-1:0]   out_idx_r;
  logic [wcf_pkg::COLOR_W-1:0]  even_r;
  logic [wcf_pkg::COLOR_W-1:0]  odd_r;
  logic                         last_r;
  logic                         adv;
  logic                         fire;
  logic                         at_last;

  // load the output register when it is empty or being taken
  assign adv     = !out_valid_r || out_pair.ready;
  assign fire    = adv && !qstat.empty;
  assign at_last = pair_r == wcf_pkg::LAST_PAIR;
  assign pop     = fire && at_last;
  assign pair_nxt = at_last ? '0 : pair_r + 1'b1;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pair_r      <= '0;
    end else begin
      if (adv)  out_valid_r <= !qstat.empty;
      if (fire) pair_r      <= pair_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_idx_r <= pair_r;
      even_r    <= wcf_pkg::led_grb({pair_r, 1'b0}, head, cfg);
      odd_r     <= wcf_pkg::led_grb({pair_r, 1'b1}, head, cfg);
      last_r    <= at_last;
    end
  end

  assign out_pair.valid      = out_valid_r;
  assign out_pair.pair_index = out_idx_r;
  assign out_pair.even_pixel = even_r;
  assign out_pair.odd_pixel  = odd_r;
  assign out_pair.last       = last_r;

endmodule

FILE: hw/rtl/german_word_clock_frame.sv
// ============================================================================
// german_word_clock_frame
// Word clock frame generator: one time beat in, 62 pixel pair beats out.
// ============================================================================
//  Channel   Dir  Beat carries
//  in_time   in   hour_in, minute_in, second_in
//  out_pair  out  pair_index, even_pixel, odd_pixel, last (GRB colors)
//  cfg_wr    in   index, data (register write, always ready)
//
//  Each time beat yields 62 pair beats, one per cycle while out_pair.ready
//  stays high; the pair serializer in the back end sets that rate.
//  A two-entry descriptor queue lets the front take new time beats while a
//  frame streams; a beat's pairs pass the queue, then the output register.
//  rst_n is synchronous and clears the queue, serializer and registers.
//  A stall on out_pair holds the current beat and pauses the serializer.
// ============================================================================
module german_word_clock_frame (
  input  logic        clk,
  input  logic        rst_n,
  wcf_cfg_if.sink     cfg_wr,
  wcf_time_if.sink    in_time,
  wcf_pair_if.source  out_pair
);

  wcf_pkg::cfg_t    cfg;
  wcf_pkg::desc_t   push_desc;
  wcf_pkg::desc_t   head;
  wcf_pkg::qstat_t  qstat;
  logic             push;
  logic             pop;

  // configuration registers
  wcf_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  // accept and classify
  wcf_front u_front (
    .show_clock (cfg.show),
    .in_time    (in_time),
    .qstat      (qstat),
    .push       (push),
    .desc       (push_desc)
  );

  // descriptor queue
  wcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // serialize pairs
  wcf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .qstat    (qstat),
    .cfg      (cfg),
    .pop      (pop),
    .out_pair (out_pair)
  );

endmodule

FILE: hw/rtl/wcf_checker.sv
// ============================================================================
// wcf_checker
// Port-level checks on the pixel pair stream, bound to the top level.
// ============================================================================
module wcf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [wcf_pkg::PAIR_W-1:0]    out_pair_index,
  input logic                          out_last
);

  // no beat right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pair beat valid right after reset");

  // stalled beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_pair_index) && $stable(out_last)))
    else $error("stalled pair beat changed");

  // last marks exactly the final pair
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_pair_index == wcf_pkg::LAST_PAIR)))
    else $error("last flag does not match final pair");

  // pairs advance by one inside a frame
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (!out_valid || (out_pair_index == ($past(out_pair_index) + 1'b1))))
    else $error("pair index skipped");

  // a new frame starts at pair zero
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=>
      (!out_valid || (out_pair_index == '0)))
    else $error("frame did not restart at pair zero");

endmodule

bind german_word_clock_frame wcf_checker u_wcf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_pair.valid),
  .out_ready      (out_pair.ready),
  .out_pair_index (out_pair.pair_index),
  .out_last       (out_pair.last)
);

FILE: test/tb_german_word_clock_frame.sv
// ============================================================================
// tb_german_word_clock_frame
// Self-checking bench for the word clock frame block. Time beats go in and
// a predicted 124-LED frame is built for each one. Every pair beat that
// leaves the block is then checked against the oldest predicted pair. Color
// settings change between phases, and each phase idles and stalls the two
// channels in its own way.
// ============================================================================
module tb_german_word_clock_frame;

  localparam int unsigned LED_COUNT     = 2 * wcf_pkg::FRAME_PAIRS;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [wcf_pkg::PAIR_W-1:0]  idx;
    logic [wcf_pkg::COLOR_W-1:0] even;
    logic [wcf_pkg::COLOR_W-1:0] odd;
    logic                        last;
  } pair_beat_t;

  // Frame predictor and store of pending pair beats
  class frame_board;
    logic                        show;
    logic [wcf_pkg::COLOR_W-1:0] act, bg, ampm, sec, minc;
    logic [wcf_pkg::COLOR_W-1:0] leds [LED_COUNT];
    pair_beat_t                  pending [$];
    int unsigned                 errors;

    function new();
      show = 1'b0;
      act = '0; bg = '0; ampm = '0; sec = '0; minc = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [wcf_pkg::CFG_IDX_W-1:0] idx,
                          logic [wcf_pkg::COLOR_W-1:0] data);
      case (idx)
        wcf_pkg::REG_SHOW_CLOCK:       show = data[0];
        wcf_pkg::REG_COLOR_ACTIVE:     act  = data;
        wcf_pkg::REG_COLOR_BACKGROUND: bg   = data;
        wcf_pkg::REG_COLOR_AMPM:       ampm = data;
        wcf_pkg::REG_COLOR_SECOND:     sec  = data;
        wcf_pkg::REG_COLOR_MINUTE:     minc = data;
        default: ;
      endcase
    endfunction

    // RGB register layout to GRB wire layout
    function logic [wcf_pkg::COLOR_W-1:0] swap_rg(logic [wcf_pkg::COLOR_W-1:0] rgb);
      return {rgb[15:8], rgb[23:16], rgb[7:0]};
    endfunction

    function void fill(int lo, int hi, logic [wcf_pkg::COLOR_W-1:0] col);
      for (int i = lo; i <= hi && i < LED_COUNT; i++) leds[i] = col;
    endfunction

    // Build the frame for one time beat and queue its 62 pair beats
    function void note_time(logic [4:0] hr, logic [5:0] mn, logic [5:0] sc);
      logic [wcf_pkg::COLOR_W-1:0] word;
      logic [wcf_pkg::COLOR_W-1:0] dot;
      int unsigned                 hw;
      logic                        vor;
      logic                        nach;
      pair_beat_t                  b;
      word = swap_rg(act);
      dot  = swap_rg(minc);
      hw   = hr % 12;
      vor  = 1'b0;
      nach = 1'b0;
      foreach (leds[i]) leds[i] = '0;
      if (show) begin
        fill(0, 109, swap_rg(bg));
        // AM lights 59-60, PM lights 70-71; each blanks the other
        if (hr >= 12) begin
          fill(59, 60, '0);
          fill(70, 71, swap_rg(ampm));
        end else begin
          fill(70, 71, '0);
          fill(59, 60, swap_rg(ampm));
        end
        // hour word, moving on to the next hour from minute 25
        if (mn >= 25) hw++;
        case (hw)
          1: begin
            if (mn < 5) fill(63, 65, word);
            else fill(62, 65, word);
          end
          2:  fill(55, 58, word);
          3:  fill(66, 69, word);
          4:  fill(73, 76, word);
          5:  fill(51, 54, word);
          6:  fill(83, 87, word);
          7:  fill(88, 93, word);
          8:  fill(77, 80, word);
          9:  fill(103, 106, word);
          10: fill(106, 109, word);
          11: fill(49, 51, word);
          default: fill(94, 98, word);
        endcase
        // minute words with VOR or NACH
        if (mn >= 55) begin
          fill(7, 10, word); vor = 1'b1;
        end else if (mn >= 50) begin
          fill(18, 21, word); vor = 1'b1;
        end else if (mn >= 45) begin
          fill(26, 32, word); vor = 1'b1;
        end else if (mn >= 40) begin
          fill(11, 17, word); vor = 1'b1;
        end else if (mn >= 35) begin
          fill(7, 10, word); fill(44, 47, word); nach = 1'b1;
        end else if (mn >= 30) begin
          fill(44, 47, word);
        end else if (mn >= 25) begin
          fill(7, 10, word); fill(44, 47, word); vor = 1'b1;
        end else if (mn >= 20) begin
          fill(11, 17, word); nach = 1'b1;
        end else if (mn >= 15) begin
          fill(26, 32, word); nach = 1'b1;
        end else if (mn >= 10) begin
          fill(18, 21, word); nach = 1'b1;
        end else if (mn >= 5) begin
          fill(7, 10, word); nach = 1'b1;
        end
        if (vor) begin
          fill(33, 36, '0); fill(41, 43, word);
        end
        if (nach) begin
          fill(41, 43, '0); fill(33, 36, word);
        end
        // minute dots
        case (mn % 5)
          0: fill(120, 123, '0);
          1: fill(122, 122, dot);
          2: fill(122, 123, dot);
          3: begin
            fill(122, 123, dot); fill(120, 120, dot);
          end
          default: fill(120, 123, dot);
        endcase
        // one seconds LED, then ES IST and UHR
        fill(110, 119, '0);
        fill(110 + sc % 10, 110 + sc % 10, swap_rg(sec));
        fill(0, 1, word);
        fill(3, 5, word);
        if (mn < 5) fill(99, 101, word);
      end
      for (int k = 0; k < wcf_pkg::FRAME_PAIRS; k++) begin
        b.idx  = wcf_pkg::PAIR_W'(k);
        b.even = leds[2*k];
        b.odd  = leds[2*k+1];
        b.last = (k == wcf_pkg::FRAME_PAIRS - 1);
        pending.push_back(b);
      end
    endfunction

    // Compare one accepted pair beat with the oldest prediction
    function void check_pair(pair_beat_t got);
      pair_beat_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pair beat: idx=%0d even=%h odd=%h last=%b",
                   got.idx, got.even, got.odd, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.idx !== want.idx || got.even !== want.even ||
          got.odd !== want.odd || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display({"pair mismatch: exp idx=%0d even=%h odd=%h last=%b",
                    " / got idx=%0d even=%h odd=%h last=%b"},
                   want.idx, want.even, want.odd, want.last,
                   got.idx, got.even, got.odd, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        rx_hold = 1'b0;
  int unsigned rx_stall = 0;
  int unsigned tx_idle = 0;
  int unsigned cycle_count;
  frame_board  board;

  wcf_cfg_if  cfg_wr ();
  wcf_time_if in_time ();
  wcf_pair_if out_pair ();

  german_word_clock_frame dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_time  (in_time),
    .out_pair (out_pair)
  );

  always #1 clk = ~clk;

  // Check pair beats and drive ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_pair.valid && out_pair.ready)
      board.check_pair(pair_beat_t'{out_pair.pair_index, out_pair.even_pixel,
                                    out_pair.odd_pixel, out_pair.last});
    out_pair.ready <= !rx_hold && ($urandom_range(99) >= rx_stall);
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic write_reg(input logic [wcf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wcf_pkg::COLOR_W-1:0] data);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= data;
    do @(posedge clk); while (!cfg_wr.ready);
    board.set_reg(idx, data);
  endtask

  task automatic load_regs(input bit shw, input logic [wcf_pkg::COLOR_W-1:0] a, b, ap,
                           sc, mc);
    write_reg(wcf_pkg::REG_SHOW_CLOCK, {{(wcf_pkg::COLOR_W-1){1'b0}}, shw});
    write_reg(wcf_pkg::REG_COLOR_ACTIVE, a);
    write_reg(wcf_pkg::REG_COLOR_BACKGROUND, b);
    write_reg(wcf_pkg::REG_COLOR_AMPM, ap);
    write_reg(wcf_pkg::REG_COLOR_SECOND, sc);
    write_reg(wcf_pkg::REG_COLOR_MINUTE, mc);
    cfg_wr.valid <= 1'b0;
  endtask

  // Offer one time beat, idling first as the phase asks; valid stays up
  task automatic send_time(input logic [4:0] hr, input logic [5:0] mn, input logic [5:0] sc);
    while ($urandom_range(99) < tx_idle) begin
      in_time.valid <= 1'b0;
      @(posedge clk);
    end
    in_time.valid     <= 1'b1;
    in_time.hour_in   <= hr;
    in_time.minute_in <= mn;
    in_time.second_in <= sc;
    do @(posedge clk); while (!in_time.ready);
    board.note_time(hr, mn, sc);
  endtask

  // Hold until every predicted pair has come out, then let the block settle
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [16:0] random_time();
    if ($urandom_range(99) < 85)
      return {5'($urandom_range(23)), 6'($urandom_range(59)), 6'($urandom_range(59))};
    return {5'($urandom), 6'($urandom), 6'($urandom)};
  endfunction

  function automatic logic [wcf_pkg::COLOR_W-1:0] random_color();
    return wcf_pkg::COLOR_W'($urandom);
  endfunction

  task automatic run_phase(input int n, input int idle_pct, input int stall_pct,
                           input bit pause_mid);
    logic [16:0] t;
    tx_idle = idle_pct;
    rx_stall <= stall_pct;
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) begin
        in_time.valid <= 1'b0;
        drain();
      end
      t = random_time();
      send_time(t[16:12], t[11:6], t[5:0]);
    end
    in_time.valid <= 1'b0;
    drain();
  endtask

  // Directed times {hour, minute, second}: every hour word, every minute
  // class, EIN and EINS, the AM/PM boundary and out-of-range fields
  logic [16:0] directed_times [24] = '{
    {5'd0, 6'd0, 6'd0},    {5'd1, 6'd3, 6'd9},    {5'd1, 6'd7, 6'd1},
    {5'd2, 6'd10, 6'd2},   {5'd3, 6'd15, 6'd3},   {5'd4, 6'd20, 6'd4},
    {5'd5, 6'd25, 6'd5},   {5'd6, 6'd30, 6'd6},   {5'd7, 6'd34, 6'd7},
    {5'd8, 6'd35, 6'd8},   {5'd9, 6'd40, 6'd59},  {5'd10, 6'd45, 6'd10},
    {5'd11, 6'd50, 6'd11}, {5'd12, 6'd55, 6'd12}, {5'd13, 6'd59, 6'd13},
    {5'd23, 6'd59, 6'd59}, {5'd24, 6'd0, 6'd0},   {5'd31, 6'd63, 6'd63},
    {5'd0, 6'd60, 6'd60},  {5'd12, 6'd24, 6'd61}, {5'd11, 6'd26, 6'd62},
    {5'd0, 6'd25, 6'd5},   {5'd5, 6'd4, 6'd4},    {5'd22, 6'd33, 6'd19}
  };

  initial begin
    board = new();
    rst_n             = 1'b0;
    cfg_wr.valid      = 1'b0;
    cfg_wr.index      = '0;
    cfg_wr.data       = '0;
    in_time.valid     = 1'b0;
    in_time.hour_in   = '0;
    in_time.minute_in = '0;
    in_time.second_in = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames with distinct colors, no idling
    load_regs(1'b1, 24'hA1B2C3, 24'h0F1E2D, 24'h3C4B5A, 24'h6978A7, 24'hB6C5D4);
    tx_idle = 0;
    rx_stall <= 0;
    foreach (directed_times[i])
      send_time(directed_times[i][16:12], directed_times[i][11:6], directed_times[i][5:0]);
    in_time.valid <= 1'b0;
    drain();

    // Random colors; the receiver holds off long enough to back up the input
    load_regs(1'b1, random_color(), random_color(), random_color(),
              random_color(), random_color());
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    run_phase(50, 0, 0, 1'b0);

    // Saturated colors on black background; sender idles, pauses midway
    load_regs(1'b1, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    run_phase(50, 68, 0, 1'b1);

    // Clock blanked; receiver stalls
    load_regs(1'b0, random_color(), random_color(), random_color(),
              random_color(), random_color());
    run_phase(40, 0, 68, 1'b0);

    // White background, black words; both sides idle lightly
    load_regs(1'b1, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000);
    run_phase(50, 10, 10, 1'b0);

    // Random colors, back to back
    load_regs(1'b1, random_color(), random_color(), random_color(),
              random_color(), random_color());
    run_phase(50, 0, 0, 1'b0);

    if (board.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
